FILE: sv/iss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iss_pkg;
  localparam int CAPACITY = 16;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = 32;

  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_PREPEND = 3'd1;
  localparam logic [2:0] KIND_INSERT  = 3'd2;
  localparam logic [2:0] KIND_REMOVE  = 3'd3;
  localparam logic [2:0] KIND_GET     = 3'd4;
  localparam logic [2:0] KIND_CLEAR   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_FETCH,
    ST_CAPT,
    ST_DEL_RD,
    ST_DEL_WR
  } state_t;
endpackage
`default_nettype wire

FILE: sv/indexed_sequence_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered store of up to CAPACITY signed 32-bit values in one synchronous RAM,
// one request at a time with one result beat per request. Get reads through
// ST_FETCH and ST_CAPT; append, prepend and insert alternate ST_INS_RD and
// ST_INS_WR per element shifted toward the tail; remove reads as get does,
// then alternates ST_DEL_RD and ST_DEL_WR per element moved toward the head;
// clear, failed and unknown requests answer from ST_IDLE. The shift runs
// read-then-write through the single RAM read port, which sets the cost per
// element. A new request is taken once the previous result beat is delivered.
module indexed_sequence_store_core import iss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_kind,
  input  wire logic signed [5:0]    in_index,
  input  wire logic signed [DW-1:0] in_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_ok,
  output logic signed [DW-1:0]      out_value_out,
  output logic [4:0]                out_count
);
  state_t          state_r, state_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [DW-1:0]   val_r, val_nxt;
  logic [DW-1:0]   res_r, res_nxt;
  logic            out_valid_r;
  logic            out_ok_r, out_ok_nxt;
  logic [DW-1:0]   out_val_r, out_val_nxt;
  logic [4:0]      out_cnt_r, out_cnt_nxt;
  logic            finish;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  logic            accept;
  logic signed [6:0] idx7, len7, ins_pos, rg_pos;
  logic            not_full, ins_ok, rg_ok;

  iss_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;

  always_comb begin
    idx7     = 7'(in_index);
    len7     = 7'(used_r);
    ins_pos  = (idx7 < 0) ? idx7 + len7 + 7'sd1 : idx7;
    rg_pos   = (idx7 < 0) ? idx7 + len7 : idx7;
    not_full = used_r < CW'(CAPACITY);
    ins_ok   = not_full && (ins_pos >= 0) && (ins_pos <= len7);
    rg_ok    = (rg_pos >= 0) && (rg_pos < len7);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_APPEND, KIND_PREPEND: if (not_full) state_nxt = ST_INS_RD;
            KIND_INSERT: if (ins_ok) state_nxt = ST_INS_RD;
            KIND_REMOVE, KIND_GET: if (rg_ok) state_nxt = ST_FETCH;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: state_nxt = (k_r == {1'b0, pos_r}) ? ST_IDLE : ST_INS_WR;
      ST_INS_WR: state_nxt = ST_INS_RD;
      ST_FETCH:  state_nxt = ST_CAPT;
      ST_CAPT:   state_nxt = (op_r == KIND_GET) ? ST_IDLE : ST_DEL_RD;
      ST_DEL_RD: state_nxt = ((k_r + CW'(1)) >= used_r) ? ST_IDLE : ST_DEL_WR;
      ST_DEL_WR: state_nxt = ST_DEL_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    used_nxt    = used_r;
    k_nxt       = k_r;
    pos_nxt     = pos_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    res_nxt     = res_r;
    finish      = 1'b0;
    out_ok_nxt  = 1'b0;
    out_val_nxt = '0;
    out_cnt_nxt = 5'(used_r);
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = val_r;
    ram_raddr   = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_kind;
          val_nxt = in_value;
          k_nxt   = used_r;
          case (in_kind)
            KIND_APPEND: begin
              pos_nxt = AW'(used_r);
              finish  = !not_full;
            end
            KIND_PREPEND: begin
              pos_nxt = '0;
              finish  = !not_full;
            end
            KIND_INSERT: begin
              pos_nxt = AW'(ins_pos);
              finish  = !ins_ok;
            end
            KIND_REMOVE, KIND_GET: begin
              pos_nxt = AW'(rg_pos);
              finish  = !rg_ok;
            end
            KIND_CLEAR: begin
              used_nxt    = '0;
              finish      = 1'b1;
              out_ok_nxt  = 1'b1;
              out_cnt_nxt = '0;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_INS_RD: begin
        if (k_r == {1'b0, pos_r}) begin
          ram_we      = 1'b1;
          used_nxt    = used_r + CW'(1);
          finish      = 1'b1;
          out_ok_nxt  = 1'b1;
          out_cnt_nxt = 5'(used_r + CW'(1));
        end else begin
          ram_raddr = AW'(k_r - CW'(1));
        end
      end
      ST_INS_WR: begin
        // move one element toward the tail
        ram_we    = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = ram_rdata;
        k_nxt     = k_r - CW'(1);
      end
      ST_FETCH: ram_raddr = pos_r;
      ST_CAPT: begin
        res_nxt = ram_rdata;
        k_nxt   = {1'b0, pos_r};
        if (op_r == KIND_GET) begin
          finish      = 1'b1;
          out_ok_nxt  = 1'b1;
          out_val_nxt = ram_rdata;
        end
      end
      ST_DEL_RD: begin
        if ((k_r + CW'(1)) >= used_r) begin
          used_nxt    = used_r - CW'(1);
          finish      = 1'b1;
          out_ok_nxt  = 1'b1;
          out_val_nxt = res_r;
          out_cnt_nxt = 5'(used_r - CW'(1));
        end else begin
          ram_raddr = AW'(k_r + CW'(1));
        end
      end
      ST_DEL_WR: begin
        // move one element toward the head
        ram_we    = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = ram_rdata;
        k_nxt     = k_r + CW'(1);
      end
      default: finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    pos_r <= pos_nxt;
    op_r  <= op_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
    if (finish) begin
      out_ok_r  <= out_ok_nxt;
      out_val_r <= out_val_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_val_r;
  assign out_count     = out_cnt_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(CAPACITY))
    else $error("element count above capacity");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending while a request is in progress");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !out_valid_r)
    else $error("result register overwritten");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || state_r != ST_IDLE))
    else $error("accepted request produced no work and no result");
endmodule
`default_nettype wire

FILE: sv/iss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
